### hdl/tfc_pkg.sv
// ----------------------------------------------------------------------------
// tfc_pkg
// Shared types, constants and the CRC step for the temperature frame checker.
// ----------------------------------------------------------------------------
package tfc_pkg;

   // Frame layout and fixed constants.
   localparam int unsigned FRAME_BYTES     = 9;
   localparam int unsigned POS_W           = $clog2(FRAME_BYTES);
   localparam int unsigned ATTEMPT_LIMIT_D = 3;
   localparam int unsigned ELAPSED_W       = 32;
   localparam int unsigned MS_PER_SEC      = 1000;
   localparam int unsigned MAG_W           = 16;
   localparam int unsigned MAG_MS_W        = 26;
   localparam int unsigned PROD_W          = 48;

   localparam logic [7:0]  CRC_POLY       = 8'h8C;
   localparam logic [15:0] POWER_ON_RAW   = 16'h0550;

   // Frame positions that carry a job of their own.
   localparam logic [POS_W-1:0] POS_LOW   = POS_W'(0);
   localparam logic [POS_W-1:0] POS_HIGH  = POS_W'(1);
   localparam logic [POS_W-1:0] POS_DIFF  = POS_W'(2);
   localparam logic [POS_W-1:0] POS_SCALE = POS_W'(3);
   localparam logic [POS_W-1:0] POS_CHECK = POS_W'(FRAME_BYTES - 1);

   // Configuration register indexes.
   localparam logic [1:0] CSR_MIN_TEMP    = 2'd0;
   localparam logic [1:0] CSR_MAX_TEMP    = 2'd1;
   localparam logic [1:0] CSR_MAX_RATE    = 2'd2;
   localparam logic [1:0] CSR_ERROR_LIMIT = 2'd3;

   // Configuration reset values.
   localparam logic signed [15:0] MIN_TEMP_RESET    = -16'sd880;
   localparam logic signed [15:0] MAX_TEMP_RESET    = 16'sd2000;
   localparam logic [15:0]        MAX_RATE_RESET    = 16'd160;
   localparam logic [7:0]         ERROR_LIMIT_RESET = 8'd5;

   typedef enum logic [1:0] {
      OP_BYTE         = 2'd0,
      OP_NO_PRES_READ = 2'd1,
      OP_NO_PRES_CONV = 2'd2,
      OP_NONE         = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_CRC         = 3'd1,
      ST_POWER_ON    = 3'd2,
      ST_RANGE       = 3'd3,
      ST_RATE        = 3'd4,
      ST_NO_PRESENCE = 3'd5
   } status_type;

   typedef struct packed {
      op_type      operation;
      logic [7:0]  data_byte;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic               retry_wanted;
      logic signed [15:0] temperature;
      logic               has_reading;
      logic               healthy;
      logic [7:0]         error_count;
   } rsp_type;

   // Frame verdict ingredients handed from the frame stage to the judging stages.
   typedef struct packed {
      op_type                operation;
      logic                  crc_bad;
      logic                  power_on;
      logic                  out_of_range;
      logic [15:0]           raw_temp;
      logic [ELAPSED_W-1:0]  elapsed;
      logic [31:0]           now_ms;
      logic [MAG_MS_W-1:0]   mag_ms;
   } chk_type;

   // One byte of the reflected CRC8, least significant bit first.
   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      logic [7:0] v;
      logic       mix;
      c = crc;
      v = data;
      for (int i = 0; i < 8; i++) begin
         mix = c[0] ^ v[0];
         c   = c >> 1;
         if (mix) begin
            c = c ^ CRC_POLY;
         end
         v = v >> 1;
      end
      return c;
   endfunction

endpackage

### hdl/tfc_frame.sv
// ----------------------------------------------------------------------------
// tfc_frame
// Input register and frame assembly: CRC, temperature bytes, change magnitude
// and the per-frame checks that need no multiplier.
// ----------------------------------------------------------------------------
module tfc_frame
   import tfc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                req_valid,
   input  req_type             req_data,
   input  logic signed [15:0]  min_temp,
   input  logic signed [15:0]  max_temp,
   input  logic signed [15:0]  last_temp,
   input  logic [31:0]         last_time,
   output logic                chk_valid,
   output chk_type             chk
);

   logic                in_valid_ff;
   req_type             in_ff;

   logic [7:0]          crc_ff, crc_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [7:0]          low_ff, low_in;
   logic [7:0]          high_ff, high_in;
   logic [MAG_W-1:0]    mag_ff, mag_in;
   logic [MAG_MS_W-1:0] mag_ms_ff, mag_ms_in;

   logic                chk_valid_ff, chk_valid_in;
   chk_type             chk_ff, chk_in;

   logic signed [15:0]  temp_now;
   logic signed [16:0]  diff;

   assign temp_now = $signed({high_ff, low_ff});
   assign diff     = 17'(temp_now) - 17'(last_temp);

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         in_ff <= req_data;
      end
   end

   // Frame assembly and the checks made when the CRC byte arrives.
   always_comb begin
      crc_in       = crc_ff;
      pos_in       = pos_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      mag_in       = mag_ff;
      mag_ms_in    = mag_ms_ff;
      chk_valid_in = 1'b0;

      chk_in.operation    = in_ff.operation;
      chk_in.crc_bad      = (crc_ff != in_ff.data_byte);
      chk_in.power_on     = ({high_ff, low_ff} == POWER_ON_RAW);
      chk_in.out_of_range = (temp_now < min_temp) || (temp_now > max_temp);
      chk_in.raw_temp     = {high_ff, low_ff};
      chk_in.elapsed      = in_ff.now_ms - last_time;
      chk_in.now_ms       = in_ff.now_ms;
      chk_in.mag_ms       = mag_ms_ff;

      if (in_valid_ff) begin
         unique case (in_ff.operation)
            OP_BYTE: begin
               if (pos_ff < POS_CHECK) begin
                  crc_in = crc8_step(crc_ff, in_ff.data_byte);
                  pos_in = pos_ff + POS_W'(1);
                  if (pos_ff == POS_LOW) begin
                     low_in = in_ff.data_byte;
                  end
                  if (pos_ff == POS_HIGH) begin
                     high_in = in_ff.data_byte;
                  end
                  // The magnitude of change is worked out in two steps while
                  // the rest of the frame streams in.
                  if (pos_ff == POS_DIFF) begin
                     mag_in = diff[16] ? MAG_W'(-diff) : MAG_W'(diff);
                  end
                  if (pos_ff == POS_SCALE) begin
                     mag_ms_in = MAG_MS_W'(mag_ff) * MAG_MS_W'(MS_PER_SEC);
                  end
               end else begin
                  crc_in       = 8'h00;
                  pos_in       = POS_LOW;
                  chk_valid_in = 1'b1;
               end
            end
            OP_NO_PRES_READ, OP_NO_PRES_CONV: begin
               crc_in       = 8'h00;
               pos_in       = POS_LOW;
               chk_valid_in = 1'b1;
            end
            OP_NONE: begin
               chk_valid_in = 1'b0;
            end
            default: begin
               chk_valid_in = 1'b0;
            end
         endcase
      end
   end

   // Frame state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= 8'h00;
         pos_ff       <= POS_LOW;
         low_ff       <= 8'h00;
         high_ff      <= 8'h00;
         chk_valid_ff <= 1'b0;
      end else if (advance) begin
         crc_ff       <= crc_in;
         pos_ff       <= pos_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         chk_valid_ff <= chk_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mag_ff    <= mag_in;
         mag_ms_ff <= mag_ms_in;
         chk_ff    <= chk_in;
      end
   end

   assign chk_valid = chk_valid_ff;
   assign chk       = chk_ff;

endmodule

### hdl/temperature_frame_checker.sv
// Only the CRC byte and presence failures give a result; other bytes give none.
// Throughput: one request per cycle through a four-register pipeline (input,
// frame check, rate product, result); a stalled result freezes every stage.
// Reset is synchronous: configuration to defaults; valids and bookkeeping clear.
// ----------------------------------------------------------------------------
// temperature_frame_checker
// Checks sensor scratchpad frames (CRC, power-on value, range, rate of change)
// and keeps the retry count, consecutive error count and last good reading.
// ----------------------------------------------------------------------------
module temperature_frame_checker
   import tfc_pkg::*;
#(
   parameter int unsigned ATTEMPT_LIMIT = ATTEMPT_LIMIT_D
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int unsigned ATT_W = $clog2(ATTEMPT_LIMIT + 1);

   logic               advance;

   logic signed [15:0] min_temp_ff;
   logic signed [15:0] max_temp_ff;
   logic [15:0]        max_rate_ff;
   logic [7:0]         error_limit_ff;

   logic               chk_valid;
   chk_type            chk;

   logic               s3_valid_ff;
   chk_type            s3_ff;
   logic [PROD_W-1:0]  prod_ff;

   logic [ATT_W-1:0]   attempt_ff, attempt_in;
   logic [7:0]         err_ff, err_in;
   logic signed [15:0] last_temp_ff, last_temp_in;
   logic [31:0]        last_time_ff, last_time_in;
   logic               seen_ff, seen_in;

   logic               rsp_valid_ff;
   rsp_type            rsp_ff, rsp_in;

   status_type         status;
   logic               read_fail;
   logic [ATT_W:0]     attempt_inc;
   logic               retry;
   logic [7:0]         err_bumped;

   // The whole pipeline moves unless a finished result is held by the receiver.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         min_temp_ff    <= MIN_TEMP_RESET;
         max_temp_ff    <= MAX_TEMP_RESET;
         max_rate_ff    <= MAX_RATE_RESET;
         error_limit_ff <= ERROR_LIMIT_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_MIN_TEMP:    min_temp_ff    <= $signed(csr_wdata);
            CSR_MAX_TEMP:    max_temp_ff    <= $signed(csr_wdata);
            CSR_MAX_RATE:    max_rate_ff    <= csr_wdata;
            CSR_ERROR_LIMIT: error_limit_ff <= csr_wdata[7:0];
            default:         error_limit_ff <= error_limit_ff;
         endcase
      end
   end

   tfc_frame u_frame (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .req_valid (req_valid),
      .req_data  (req_data),
      .min_temp  (min_temp_ff),
      .max_temp  (max_temp_ff),
      .last_temp (last_temp_ff),
      .last_time (last_time_ff),
      .chk_valid (chk_valid),
      .chk       (chk)
   );

   // Rate product: allowed change scaled by the elapsed milliseconds.
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= chk_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_ff   <= chk;
         prod_ff <= PROD_W'(max_rate_ff) * PROD_W'(chk.elapsed);
      end
   end

   // Verdict in order of precedence.
   always_comb begin
      if (s3_ff.operation != OP_BYTE) begin
         status = ST_NO_PRESENCE;
      end else if (s3_ff.crc_bad) begin
         status = ST_CRC;
      end else if (s3_ff.power_on) begin
         status = ST_POWER_ON;
      end else if (s3_ff.out_of_range) begin
         status = ST_RANGE;
      end else if (seen_ff && (s3_ff.elapsed != '0)
                   && (PROD_W'(s3_ff.mag_ms) > prod_ff)) begin
         status = ST_RATE;
      end else begin
         status = ST_OK;
      end
   end

   assign read_fail   = (s3_ff.operation == OP_NO_PRES_READ)
                        || (status == ST_CRC) || (status == ST_POWER_ON);
   assign attempt_inc = (ATT_W + 1)'(attempt_ff) + (ATT_W + 1)'(1);
   assign retry       = read_fail && (attempt_inc < (ATT_W + 1)'(ATTEMPT_LIMIT));
   assign err_bumped  = (err_ff == 8'hFF) ? err_ff : err_ff + 8'd1;

   // Retry and error bookkeeping, and the last good reading.
   always_comb begin
      attempt_in   = attempt_ff;
      err_in       = err_ff;
      last_temp_in = last_temp_ff;
      last_time_in = last_time_ff;
      seen_in      = seen_ff;
      if (s3_valid_ff) begin
         if (status == ST_OK) begin
            attempt_in   = '0;
            err_in       = 8'h00;
            last_temp_in = $signed(s3_ff.raw_temp);
            last_time_in = s3_ff.now_ms;
            seen_in      = 1'b1;
         end else if (retry) begin
            attempt_in = attempt_inc[ATT_W-1:0];
         end else begin
            attempt_in = '0;
            err_in     = err_bumped;
         end
      end
   end

   always_comb begin
      rsp_in.status       = status;
      rsp_in.retry_wanted = retry;
      rsp_in.temperature  = last_temp_in;
      rsp_in.has_reading  = seen_in;
      rsp_in.healthy      = (err_in < error_limit_ff);
      rsp_in.error_count  = err_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attempt_ff   <= '0;
         err_ff       <= 8'h00;
         last_temp_ff <= 16'sd0;
         last_time_ff <= 32'd0;
         seen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         attempt_ff   <= attempt_in;
         err_ff       <= err_in;
         last_temp_ff <= last_temp_in;
         last_time_ff <= last_time_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // The retry counter never reaches the attempt limit.
   a_attempt_bound: assert property (@(posedge clock) disable iff (reset)
      attempt_ff < ATT_W'(ATTEMPT_LIMIT))
      else $error("attempt counter reached the attempt limit");

   // A retry is only asked for after a read failure.
   a_retry_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.retry_wanted |->
         (rsp_ff.status == ST_CRC) || (rsp_ff.status == ST_POWER_ON)
         || (rsp_ff.status == ST_NO_PRESENCE))
      else $error("retry requested without a read failure");

   // An accepted frame clears the error count and marks a reading.
   a_accept_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.status == ST_OK) |->
         (rsp_ff.error_count == 8'h00) && rsp_ff.has_reading)
      else $error("accepted frame left errors or no reading");

   // Health follows the error count and the limit.
   a_health: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.healthy == (rsp_ff.error_count < error_limit_ff))
      else $error("health flag disagrees with error count");
`endif

endmodule
